@@ rtl/cmap_pkg.sv @@
// Shared constants, command and status structs for the clamped moving average block.
// No dependencies; compiled first.
package cmap_pkg;

    // Default configuration of the block
    localparam int DEPTH_DEF       = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    // Percentage scale and result width
    localparam int PCT_SCALE = 100;
    localparam int PCT_BITS  = 7;

    // Configuration register indexes; any other index is ignored
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRY_LEVEL = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // take the input word and clamp it
        logic update;     // write ring, update total, slot and count
        logic div_start;  // load the divider
        logic div_pct;    // divider operands: percentage instead of mean
        logic load_mean;  // store divider quotient as the mean
        logic pct_prep;   // form numerator, denominator and range flags
        logic load_out;   // load the result word registers
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_busy;
    } status_t;

endpackage

@@ rtl/cmap_if.sv @@
// Valid/ready channel interfaces for sample input and result output words.
// Depends on cmap_pkg for default widths.
interface cmap_in_if #(
    parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface cmap_out_if #(
    parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = $clog2(cmap_pkg::DEPTH_DEF + 1)
) ();
    logic                          valid;
    logic                          ready;
    logic [cmap_pkg::PCT_BITS-1:0] humidity_percent;
    logic [SAMPLE_BITS-1:0]        mean_reading;
    logic [COUNT_BITS-1:0]         valid_samples;
    logic                          calibration_bad;

    modport source (output valid, output humidity_percent, output mean_reading,
                    output valid_samples, output calibration_bad, input ready);
    modport sink   (input valid, input humidity_percent, input mean_reading,
                    input valid_samples, input calibration_bad, output ready);
endinterface

@@ rtl/cmap_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Requires dividend < divisor * 2**Q_BITS. No package dependencies.
module cmap_div #(
    parameter int DVS_BITS = 12,
    parameter int Q_BITS   = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DVS_BITS+Q_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0]        divisor,
    output logic                       busy,
    output logic [Q_BITS-1:0]          quotient
);

    localparam int W_BITS    = DVS_BITS + Q_BITS;
    localparam int STEP_BITS = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;

    logic [W_BITS-1:0]    rem_reg;
    logic [W_BITS-1:0]    dsh_reg;
    logic [Q_BITS-1:0]    q_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 busy_reg;
    logic                 fits;

    assign fits = (rem_reg >= dsh_reg);

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_BITS'(Q_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    // Subtract the shifted divisor where it fits, shift in one quotient bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= W_BITS'(divisor) << (Q_BITS - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_BITS-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/cmap_datapath.sv @@
// Datapath: calibration registers, sample ring memory, running total,
// shared divider and result registers. Depends on cmap_pkg and cmap_div.
module cmap_datapath #(
    parameter int DEPTH       = cmap_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmap_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data,
    input  logic [SAMPLE_BITS-1:0]            adc_sample,
    input  cmap_pkg::cmd_t                    cmd,
    output cmap_pkg::status_t                 status,
    output logic [cmap_pkg::PCT_BITS-1:0]     humidity_percent,
    output logic [SAMPLE_BITS-1:0]            mean_reading,
    output logic [COUNT_BITS-1:0]             valid_samples,
    output logic                              calibration_bad
);

    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int TOT_BITS  = SAMPLE_BITS + IDX_BITS;
    localparam int DVS_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
    localparam int DIV_BITS  = DVS_BITS + SAMPLE_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + cmap_pkg::PCT_BITS;
    localparam int PB        = cmap_pkg::PCT_BITS;

    // Calibration registers
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] max_reg;

    // Ring state
    logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_BITS-1:0]    slot_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [TOT_BITS-1:0]    total_reg;

    // Percentage stage
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [PROD_BITS-1:0]   num_reg;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic                   bad_reg;
    logic                   above_reg;
    logic                   below_reg;

    // Result registers
    logic [PB-1:0]          pct_out_reg;
    logic [SAMPLE_BITS-1:0] mean_out_reg;
    logic [COUNT_BITS-1:0]  cnt_out_reg;
    logic                   bad_out_reg;

    logic [SAMPLE_BITS-1:0] floor_v;
    logic [SAMPLE_BITS-1:0] clamped;
    logic                   full;
    logic [SAMPLE_BITS-1:0] old_v;
    logic [DIV_BITS-1:0]    div_dividend;
    logic [DVS_BITS-1:0]    div_divisor;
    logic                   div_busy;
    logic [SAMPLE_BITS-1:0] div_q;
    logic [PB-1:0]          pct_v;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmap_pkg::CFG_WET_LEVEL: min_reg <= cfg_data;
                cmap_pkg::CFG_DRY_LEVEL: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the incoming sample: max(min) first, then min(max)
    assign floor_v = (adc_sample < min_reg) ? min_reg : adc_sample;
    assign clamped = (floor_v > max_reg) ? max_reg : floor_v;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= clamped;
        end
    end

    // Ring memory: one write, one registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
        rd_reg <= ring_mem[slot_reg];
    end

    // Slots not yet written read as zero until the ring is full
    assign full  = (cnt_reg == COUNT_BITS'(DEPTH));
    assign old_v = full ? rd_reg : '0;

    // Advance slot, count and running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
        end
        else if (cmd.update)
        begin
            total_reg <= total_reg - TOT_BITS'(old_v) + TOT_BITS'(sample_reg);
            if (slot_reg == IDX_BITS'(DEPTH - 1))
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            if (!full)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Divider operands: total / count for the mean, scaled span / range for percent
    assign div_dividend = cmd.div_pct ? DIV_BITS'(num_reg) : DIV_BITS'(total_reg);
    assign div_divisor  = cmd.div_pct ? DVS_BITS'(den_reg) : DVS_BITS'(cnt_reg);

    cmap_div #(
        .DVS_BITS (DVS_BITS),
        .Q_BITS   (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.div_busy = div_busy;

    // Hold the mean, then form the percentage operands and range flags
    always_ff @(posedge clk)
    begin
        if (cmd.load_mean)
        begin
            mean_reg <= div_q;
        end
        if (cmd.pct_prep)
        begin
            num_reg   <= PROD_BITS'(max_reg - mean_reg) * PROD_BITS'(cmap_pkg::PCT_SCALE);
            den_reg   <= max_reg - min_reg;
            bad_reg   <= (max_reg <= min_reg);
            above_reg <= (mean_reg >= max_reg);
            below_reg <= (mean_reg <= min_reg);
        end
    end

    // Pick the percentage: bad range and dry end give 0, wet end gives full scale
    always_comb
    begin
        priority if (bad_reg || above_reg)
        begin
            pct_v = '0;
        end
        else if (below_reg)
        begin
            pct_v = PB'(cmap_pkg::PCT_SCALE);
        end
        else
        begin
            pct_v = div_q[PB-1:0];
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pct_out_reg  <= pct_v;
            mean_out_reg <= mean_reg;
            cnt_out_reg  <= cnt_reg;
            bad_out_reg  <= bad_reg;
        end
    end

    assign humidity_percent = pct_out_reg;
    assign mean_reading     = mean_out_reg;
    assign valid_samples    = cnt_out_reg;
    assign calibration_bad  = bad_out_reg;

endmodule

@@ rtl/cmap_ctrl.sv @@
// Controller state machine: sequences ring update, mean and percentage divisions
// and the output register handshake. Depends on cmap_pkg.
module cmap_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cmap_pkg::status_t   status,
    output cmap_pkg::cmd_t      cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_UPDATE    = 7'b0000010,
        ST_MEAN_GO   = 7'b0000100,
        ST_MEAN_WAIT = 7'b0001000,
        ST_PCT_PREP  = 7'b0010000,
        ST_PCT_GO    = 7'b0100000,
        ST_PCT_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.load_mean = 1'b1;
                    state_next    = ST_PCT_PREP;
                end
            end
            ST_PCT_PREP:
            begin
                cmd.pct_prep = 1'b1;
                state_next   = ST_PCT_GO;
            end
            ST_PCT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_pct   = 1'b1;
                state_next    = ST_PCT_WAIT;
            end
            ST_PCT_WAIT:
            begin
                if (!status.div_busy && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/clamped_moving_average_percent.sv @@
// Top level of the clamped moving average with percentage calibration.
// Depends on cmap_pkg, cmap_if, cmap_ctrl, cmap_datapath (and cmap_div).
//
// Usage:
//   sample  : valid/ready input channel, one adc_sample word per item.
//   result  : valid/ready output channel, one word per accepted sample with
//             humidity_percent, mean_reading, valid_samples, calibration_bad.
//   cfg_*   : write port for the wet level (index 0) and the dry level (index 1);
//             other indexes are ignored; write only while no item is in flight.
// Each sample is clamped to [wet level, dry level], stored in a ring of DEPTH
// entries and averaged over the filled entries; the percentage maps
// the dry level to 0 and the wet level to 100.
// Timing: one item at a time. The result is computed by two divisions on the
// shared one-bit-per-cycle divider, and the next sample can be taken once the
// result word has been loaded into the output register.
// Reset clears the ring pointer, fill count, running total and calibration
// (wet level 0, dry level all ones); ring slots not yet written read as zero.
// A stalled receiver holds the result in the output register; the next sample
// is still taken and processed, and its result waits until that word is taken.
module clamped_moving_average_percent #(
    parameter int DEPTH       = cmap_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmap_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data,
    cmap_in_if.sink                           sample,
    cmap_out_if.source                        result
);

    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    cmap_pkg::cmd_t    cmd;
    cmap_pkg::status_t status;

    cmap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cmap_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .adc_sample       (sample.adc_sample),
        .cmd              (cmd),
        .status           (status),
        .humidity_percent (result.humidity_percent),
        .mean_reading     (result.mean_reading),
        .valid_samples    (result.valid_samples),
        .calibration_bad  (result.calibration_bad)
    );

    // One item at a time: input closes right after a word is taken
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("input accepted while an item is in flight");

    // Bad calibration forces the percentage to zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.calibration_bad |-> result.humidity_percent == '0)
        else $error("percentage nonzero with bad calibration");

    // Percentage stays within full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.humidity_percent <= cmap_pkg::PCT_BITS'(cmap_pkg::PCT_SCALE))
        else $error("percentage above full scale");

    // Averaged count lies in 1..DEPTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.valid_samples != '0) &&
                         (result.valid_samples <= COUNT_BITS'(DEPTH)))
        else $error("valid sample count out of range");

endmodule
